// ===== rtl/cfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cfs_pkg: shared types and constants of the circular fifo with search
// Item and result layouts, the decoded operation set, sequencer states and
// reset value of the configuration register.
// ----------------------------------------------------------------------------
package cfs_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int FIELD_W       = 32;
    localparam int CAP_W         = 5;
    localparam int OCC_W         = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [2:0] ACT_ENQUEUE     = 3'd0;
    localparam logic [2:0] ACT_DEQUEUE     = 3'd1;
    localparam logic [2:0] ACT_PEEK_OLDEST = 3'd2;
    localparam logic [2:0] ACT_PEEK_NEWEST = 3'd3;
    localparam logic [2:0] ACT_CLEAR       = 3'd4;
    localparam logic [2:0] ACT_SEARCH      = 3'd5;

    typedef enum logic [2:0] {
        OP_ENQ,
        OP_DEQ,
        OP_PKO,
        OP_PKN,
        OP_CLR,
        OP_SRC,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH
    } state_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [FIELD_W-1:0] item_data;
        logic [FIELD_W-1:0] item_tag;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic [FIELD_W-1:0] out_data;
        logic [FIELD_W-1:0] out_tag;
        logic [OCC_W-1:0]   occupancy;
        logic               is_empty;
        logic               is_full;
    } res_item_t;

    typedef struct packed {
        op_t                op;
        logic [FIELD_W-1:0] data;
        logic [FIELD_W-1:0] tag;
    } cmd_t;

    typedef struct packed {
        logic [FIELD_W-1:0] data;
        logic [FIELD_W-1:0] tag;
    } entry_t;

endpackage

// ===== rtl/cfs_front.sv =====
// ----------------------------------------------------------------------------
// cfs_front: input side of the circular fifo with search
// Accepts input transactions, decodes the action into an operation and
// holds up to two decoded commands for the back end.
// ----------------------------------------------------------------------------
module cfs_front
    import cfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    cmd_t       dec;
    logic       wr_en;
    logic       rd_en;

    always_comb
    begin
        dec.data = item.item_data;
        dec.tag  = item.item_tag;
        unique case (item.action)
            ACT_ENQUEUE:     dec.op = OP_ENQ;
            ACT_DEQUEUE:     dec.op = OP_DEQ;
            ACT_PEEK_OLDEST: dec.op = OP_PKO;
            ACT_PEEK_NEWEST: dec.op = OP_PKN;
            ACT_CLEAR:       dec.op = OP_CLR;
            ACT_SEARCH:      dec.op = OP_SRC;
            default:         dec.op = OP_NOP;
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_valid && cmd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/cfs_resq.sv =====
// ----------------------------------------------------------------------------
// cfs_resq: result queue of the circular fifo with search
// Two-entry queue that holds finished results until the receiver pops them.
// ----------------------------------------------------------------------------
module cfs_resq
    import cfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_push,
    input  res_item_t res_in,
    output logic      res_full,
    output logic      empty,
    input  logic      pop,
    output res_item_t result
);

    res_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_en;
    logic       rd_en;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign result   = slot_reg[rd_ptr_reg];
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/cfs_back.sv =====
// ----------------------------------------------------------------------------
// cfs_back: execution side of the circular fifo with search
// Owns the ring memory and its pointers, carries out one command at a time
// and walks the live entries one per cycle for a search.
// ----------------------------------------------------------------------------
module cfs_back
    import cfs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CAP_W-1:0] capacity_in_use,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    input  logic             res_full,
    output logic             res_push,
    output res_item_t        res_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    entry_t            mem [DEPTH];
    entry_t            rd_data_reg;
    state_t            state_reg;
    state_t            state_next;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [AW-1:0]     newest_reg;
    logic [AW-1:0]     newest_next;
    logic [CW-1:0]     live_reg;
    logic [CW-1:0]     live_next;
    logic [AW-1:0]     srch_idx_reg;
    logic [AW-1:0]     srch_idx_next;
    logic [CW-1:0]     srch_cnt_reg;
    logic [CW-1:0]     srch_cnt_next;
    logic [FIELD_W-1:0] key_reg;
    logic [FIELD_W-1:0] key_next;
    logic [CW-1:0]     cap_eff;
    logic              take;
    logic              live_zero;
    logic              hit;
    logic              last;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     enq_idx;
    logic [AW-1:0]     srch_step;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i,
                                                input logic [CW-1:0] c);
        logic [CW-1:0] n;
        n = CW'(i) + CW'(1);
        return (n >= c) ? '0 : n[AW-1:0];
    endfunction

    function automatic res_item_t status(input logic [CW-1:0] live,
                                         input logic [CW-1:0] c);
        res_item_t r;
        r           = '0;
        r.occupancy = OCC_W'(live);
        r.is_empty  = (live == '0);
        r.is_full   = (live >= c);
        return r;
    endfunction

    always_comb
    begin
        if (capacity_in_use == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (32'(capacity_in_use) >= 32'(DEPTH))
        begin
            cap_eff = DEPTH_C;
        end
        else
        begin
            cap_eff = CW'(capacity_in_use);
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE) && !res_full;
    assign take      = cmd_valid && cmd_ready;
    assign live_zero = (live_reg == '0);
    assign hit       = (rd_data_reg.data == key_reg);
    assign last      = ((srch_cnt_reg + CW'(1)) == live_reg);
    assign enq_idx   = live_zero ? '0 : next_slot(newest_reg, cap_eff);
    assign srch_step = next_slot(srch_idx_reg, cap_eff);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && !live_zero)
                begin
                    if (cmd.op == OP_DEQ || cmd.op == OP_PKO || cmd.op == OP_PKN)
                    begin
                        state_next = ST_READ;
                    end
                    else if (cmd.op == OP_SRC)
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_SEARCH:
            begin
                if (hit || last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        head_next     = head_reg;
        newest_next   = newest_reg;
        live_next     = live_reg;
        srch_idx_next = srch_idx_reg;
        srch_cnt_next = srch_cnt_reg;
        key_next      = key_reg;
        mem_we        = 1'b0;
        mem_waddr     = enq_idx;
        rd_en         = 1'b0;
        rd_addr       = head_reg;
        res_push      = 1'b0;
        res_out       = status(live_reg, cap_eff);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (cmd.op)
                        OP_ENQ:
                        begin
                            res_push = 1'b1;
                            if (live_reg < cap_eff)
                            begin
                                mem_we      = 1'b1;
                                newest_next = enq_idx;
                                if (live_zero)
                                begin
                                    head_next = '0;
                                end
                                live_next  = live_reg + CW'(1);
                                res_out    = status(live_next, cap_eff);
                                res_out.ok = 1'b1;
                            end
                        end
                        OP_DEQ:
                        begin
                            if (live_zero)
                            begin
                                res_push = 1'b1;
                            end
                            else
                            begin
                                rd_en     = 1'b1;
                                live_next = live_reg - CW'(1);
                                if (live_next == '0)
                                begin
                                    head_next   = '0;
                                    newest_next = LAST_SLOT;
                                end
                                else
                                begin
                                    head_next = next_slot(head_reg, cap_eff);
                                end
                            end
                        end
                        OP_PKO:
                        begin
                            if (live_zero)
                            begin
                                res_push = 1'b1;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                            end
                        end
                        OP_PKN:
                        begin
                            rd_addr = newest_reg;
                            if (live_zero)
                            begin
                                res_push = 1'b1;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                            end
                        end
                        OP_CLR:
                        begin
                            head_next   = '0;
                            newest_next = LAST_SLOT;
                            live_next   = '0;
                            res_push    = 1'b1;
                            res_out     = status('0, cap_eff);
                            res_out.ok  = 1'b1;
                        end
                        OP_SRC:
                        begin
                            srch_idx_next = head_reg;
                            srch_cnt_next = '0;
                            key_next      = cmd.data;
                            if (live_zero)
                            begin
                                res_push = 1'b1;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_push         = 1'b1;
                res_out.ok       = 1'b1;
                res_out.out_data = rd_data_reg.data;
                res_out.out_tag  = rd_data_reg.tag;
            end
            ST_SEARCH:
            begin
                if (hit || last)
                begin
                    res_push   = 1'b1;
                    res_out.ok = hit;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = srch_step;
                    srch_idx_next = srch_step;
                    srch_cnt_next = srch_cnt_reg + CW'(1);
                end
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= '{data: cmd.data, tag: cmd.tag};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        srch_idx_reg <= srch_idx_next;
        srch_cnt_reg <= srch_cnt_next;
        key_reg      <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            newest_reg <= LAST_SLOT;
            live_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            newest_reg <= newest_next;
            live_reg   <= live_next;
        end
    end

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full result queue");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= DEPTH_C)
        else $error("live count beyond depth");

    a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_SEARCH) && $past(take) |->
        ($past(live_reg) != '0))
        else $error("read or search started on an empty queue");

    a_empty_home: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg == '0) |-> (head_reg == '0))
        else $error("head not at slot zero while empty");

    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_IDLE))
        else $error("read state held longer than one cycle");

endmodule

// ===== rtl/circular_fifo_with_search.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_with_search: ring-buffer fifo with peek, clear and search
// Command queue in front, ring memory sequencer behind, result queue out.
//
// Usage:
//   item channel: push/full; a transaction is taken when push is high and
//     full is low. Each carries an action, a data word and a tag.
//   result channel: empty/pop; the oldest result sits on result while empty
//     is low and leaves when pop is high. Exactly one result per item.
//   cfg channel: cfg_valid/cfg_ready, always ready; cfg_data sets the number
//     of ring slots in use (0 acts as 1, above DEPTH acts as DEPTH). Write it
//     only while no item is in flight.
//   path: dequeue and peeks add the registered ring read of ST_READ, and
//     a search compares the live entries in turn until a hit or the last.
//   throughput: one item per cycle for enqueue and clear while the result
//     queue has room; dequeue, peeks and search hold the single sequencer
//     until their result is pushed, through its registered ring read port.
//   reset: queues and pointers clear at once, capacity returns to 16, ring
//     contents are not cleared. When pop is held low the result queue fills,
//     the sequencer stops, then the command queue fills and full rises.
// ----------------------------------------------------------------------------
module circular_fifo_with_search
    import cfs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  in_item_t         item,
    output logic             empty,
    input  logic             pop,
    output res_item_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    logic [CAP_W-1:0] capacity_reg;
    logic             cmd_valid;
    logic             cmd_ready;
    cmd_t             cmd;
    logic             res_full;
    logic             res_push;
    res_item_t        res_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= cfg_data;
        end
    end

    cfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    cfs_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .capacity_in_use (capacity_reg),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .res_full        (res_full),
        .res_push        (res_push),
        .res_out         (res_out)
    );

    cfs_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_out),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

// ===== bench/tb_circular_fifo_with_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_fifo_with_search: self-checking bench for the searchable ring fifo
// Drives enqueue, dequeue, peek, clear and search transactions with random
// gaps on the item side and random stalls on the result side. A behavioral
// copy of the ring predicts every result, which is compared field by field.
// The capacity register is changed between phases, shrinking below the live
// count and going past both ends of its range.
// ----------------------------------------------------------------------------
module tb_circular_fifo_with_search;
    import cfs_pkg::*;

    localparam int RING_DEPTH    = DEPTH_DEFAULT;
    localparam int POS_W         = $clog2(RING_DEPTH);
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 110;
    localparam int MAX_PRINTS    = 50;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             push;
    logic             full;
    in_item_t         item;
    logic             empty;
    logic             pop = 1'b0;
    res_item_t        result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    // predictor state
    entry_t           ring_copy [RING_DEPTH];
    logic [POS_W-1:0] head_pos   = '0;
    logic [POS_W-1:0] newest_pos = '1;
    int               live_cnt   = 0;
    logic [CAP_W-1:0] cap_setting = CAP_RESET;

    res_item_t   pending_results [$];
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          idle_off       = 1'b0;
    int          pop_stall      = 0;

    logic [CAP_W-1:0] phase_caps [13] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd2, 5'd16,
                                          5'd9, 5'd3, 5'd17, 5'd7, 5'd12, 5'd16};

    circular_fifo_with_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int cap_eff();
        if (cap_setting == 0)
            return 1;
        if (cap_setting > RING_DEPTH)
            return RING_DEPTH;
        return int'(cap_setting);
    endfunction

    function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
        int n;
        n = int'(p) + 1;
        return (n >= cap_eff()) ? '0 : POS_W'(n);
    endfunction

    function automatic res_item_t predict_fifo_result(input in_item_t it);
        res_item_t        r;
        logic [POS_W-1:0] idx;
        r = '0;
        case (it.action)
            ACT_ENQUEUE:
            begin
                if (live_cnt < cap_eff())
                begin
                    newest_pos = (live_cnt == 0) ? '0 : next_pos(newest_pos);
                    if (live_cnt == 0)
                        head_pos = '0;
                    ring_copy[newest_pos] = '{data: it.item_data, tag: it.item_tag};
                    live_cnt++;
                    r.ok = 1'b1;
                end
            end
            ACT_DEQUEUE:
            begin
                if (live_cnt != 0)
                begin
                    r.out_data = ring_copy[head_pos].data;
                    r.out_tag  = ring_copy[head_pos].tag;
                    head_pos   = next_pos(head_pos);
                    live_cnt--;
                    if (live_cnt == 0)
                    begin
                        head_pos   = '0;
                        newest_pos = '1;
                    end
                    r.ok = 1'b1;
                end
            end
            ACT_PEEK_OLDEST:
            begin
                if (live_cnt != 0)
                begin
                    r.out_data = ring_copy[head_pos].data;
                    r.out_tag  = ring_copy[head_pos].tag;
                    r.ok       = 1'b1;
                end
            end
            ACT_PEEK_NEWEST:
            begin
                if (live_cnt != 0)
                begin
                    r.out_data = ring_copy[newest_pos].data;
                    r.out_tag  = ring_copy[newest_pos].tag;
                    r.ok       = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                head_pos   = '0;
                newest_pos = '1;
                live_cnt   = 0;
                r.ok       = 1'b1;
            end
            ACT_SEARCH:
            begin
                idx = head_pos;
                for (int i = 0; i < live_cnt; i++)
                begin
                    if (ring_copy[idx].data == it.item_data)
                    begin
                        r.ok = 1'b1;
                        break;
                    end
                    idx = next_pos(idx);
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = OCC_W'(live_cnt);
        r.is_empty  = (live_cnt == 0);
        r.is_full   = (live_cnt >= cap_eff());
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        if (idle_off)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic in_item_t make_item(input logic [2:0] act,
                                           input logic [FIELD_W-1:0] data,
                                           input logic [FIELD_W-1:0] tag);
        in_item_t it;
        it.action    = act;
        it.item_data = data;
        it.item_tag  = tag;
        return it;
    endfunction

    function automatic logic [FIELD_W-1:0] random_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return FIELD_W'($urandom_range(0, 7));
        return $urandom();
    endfunction

    function automatic in_item_t random_item(input int enq_bias);
        in_item_t         it;
        int               r;
        logic [POS_W-1:0] idx;
        it = make_item(ACT_ENQUEUE, random_word(), random_word());
        r  = $urandom_range(0, 99);
        if (r >= enq_bias)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                it.action = ACT_DEQUEUE;
            else if (r < 54)
                it.action = ACT_PEEK_OLDEST;
            else if (r < 68)
                it.action = ACT_PEEK_NEWEST;
            else if (r < 92)
                it.action = ACT_SEARCH;
            else if (r < 97)
                it.action = ACT_CLEAR;
            else
                it.action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
        end
        // aim most searches at a live entry
        if (it.action == ACT_SEARCH && live_cnt > 0 && $urandom_range(0, 99) < 65)
        begin
            idx = head_pos;
            repeat ($urandom_range(0, live_cnt - 1))
                idx = next_pos(idx);
            it.item_data = ring_copy[idx].data;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic compare_field(input string name, input logic [FIELD_W-1:0] got,
                                 input logic [FIELD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic check_result(input res_item_t got);
        res_item_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result transaction with no item pending");
            return;
        end
        want = pending_results.pop_front();
        compare_field("ok", FIELD_W'(got.ok), FIELD_W'(want.ok));
        compare_field("out_data", got.out_data, want.out_data);
        compare_field("out_tag", got.out_tag, want.out_tag);
        compare_field("occupancy", FIELD_W'(got.occupancy), FIELD_W'(want.occupancy));
        compare_field("is_empty", FIELD_W'(got.is_empty), FIELD_W'(want.is_empty));
        compare_field("is_full", FIELD_W'(got.is_full), FIELD_W'(want.is_full));
    endtask

    // result side: check accepted transactions, stall pop at random
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_result(result);
        if (pop_stall > 0)
        begin
            pop <= 1'b0;
            pop_stall--;
        end
        else
        begin
            pop <= 1'b1;
            pop_stall = idle_gap();
        end
    end

    task automatic send_item(input in_item_t it);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
        begin
            @(posedge clk);
        end
        while (full);
        pending_results.push_back(predict_fifo_result(it));
    endtask

    task automatic settle_block();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        cap_setting = cap;
    endtask

    task automatic test_empty_queue();
        send_item(make_item(ACT_DEQUEUE, '1, '1));
        send_item(make_item(ACT_PEEK_OLDEST, '0, '0));
        send_item(make_item(ACT_PEEK_NEWEST, '1, '0));
        send_item(make_item(ACT_SEARCH, '0, '1));
        send_item(make_item(ACT_SPARE_LO, '1, '1));
        send_item(make_item(ACT_SPARE_HI, '0, '0));
    endtask

    // writes every ring slot once, so later walks never hit an unwritten slot
    task automatic test_fill_ring();
        logic [FIELD_W-1:0] word;
        idle_off = 1'b1;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            case (i)
                0:       word = '0;
                1:       word = '1;
                2:       word = 32'h5555_5555;
                3:       word = 32'haaaa_aaaa;
                default: word = FIELD_W'(i) * 32'h0101_0101;
            endcase
            send_item(make_item(ACT_ENQUEUE, word, ~word));
        end
        send_item(make_item(ACT_ENQUEUE, 32'h1234_5678, 32'h8765_4321));
        send_item(make_item(ACT_SEARCH, '1, '0));
        idle_off = 1'b0;
    endtask

    task automatic test_shrunk_capacity();
        write_capacity(5'd2);
        send_item(make_item(ACT_ENQUEUE, $urandom(), $urandom()));
        send_item(make_item(ACT_DEQUEUE, '0, '0));
        send_item(make_item(ACT_PEEK_OLDEST, '0, '0));
        send_item(make_item(ACT_SEARCH, 32'h5555_5555, '0));
        send_item(make_item(ACT_CLEAR, '0, '0));
    endtask

    task automatic test_random_phases();
        int burst_left;
        int enq_bias;
        for (int p = 0; p < $size(phase_caps); p++)
        begin
            write_capacity(phase_caps[p]);
            idle_off   = (p % 4 == 3);
            burst_left = 0;
            enq_bias   = 50;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // mix filling and draining bursts at random
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(4, 30);
                    enq_bias   = $urandom_range(0, 1) ? $urandom_range(55, 85)
                                                      : $urandom_range(10, 35);
                end
                burst_left--;
                send_item(random_item(enq_bias));
            end
        end
        idle_off = 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        push      <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fill_ring();
        test_shrunk_capacity();
        test_random_phases();

        settle_block();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
